// ===== rtl/core/mae_pkg.sv =====
// Shared constants, types and command structures of the multiloop asymmetry energy block.
package mae_pkg;

  // Base index width and accumulator widths.
  localparam int IDX_W  = 16;
  localparam int ASYM_W = 18;
  localparam int BR_W   = 16;
  localparam int UP_W   = 17;
  localparam int TOT_W  = 17;
  localparam int E_W    = 32;
  localparam int CFG_W  = 16;

  // Energy arithmetic.
  localparam int ENERGY_SCALE = 10;
  localparam int ACC_E_W      = 36;
  localparam int MUL_A_W      = ASYM_W + 1;
  localparam int MUL_B_W      = CFG_W + 2;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int CMAG_W       = CFG_W + 1;
  localparam int MAG_W        = 34;
  localparam int NUM_W        = 38;
  localparam int CMP_W        = 32;
  localparam int AVG_SHIFT    = 8;
  localparam int CAP_SHIFT    = 16;
  localparam int HALF_SHIFT   = 7;

  // Divider: one quotient bit per cycle.
  localparam int Q_W       = 19;
  localparam int REM_W     = BR_W;
  localparam int DIV_STEPS = Q_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Loop shape constants.
  localparam int BRANCH_BASE     = 2;
  localparam int STRAIN_BRANCHES = 3;
  localparam int STRAIN_UNPAIRED = 2;

  // Register map.
  localparam int REG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;
  localparam int APB_W      = 32;
  localparam logic [REG_IDX_W-1:0] REG_INIT     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BRANCH   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_UNPAIRED = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STRAIN   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CAP      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COEFF    = 3'd5;

  // Configuration register values.
  typedef struct packed {
    logic [CFG_W-1:0] init_cost;
    logic [CFG_W-1:0] branch_cost;
    logic [CFG_W-1:0] unpaired_cost;
    logic [CFG_W-1:0] strain_cost;
    logic [CFG_W-1:0] max_avg_asym_q8;
    logic [CFG_W-1:0] asym_coeff_q8;
  } mae_cfg_t;

  // Operand pairs of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_CAP,
    MUL_BR,
    MUL_UP,
    MUL_ASYM
  } mae_mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         take_item;
    logic         fin_gap;
    logic         fin_wrap;
    logic         mul_en;
    mae_mul_sel_t mul_sel;
    logic         cmp_cap;
    logic         acc_init;
    logic         acc_add;
    logic         scale;
    logic         div_step;
    logic         load_out;
  } mae_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic capped;
  } mae_status_t;

endpackage

// ===== rtl/core/mae_if.sv =====
// Valid/ready channel interfaces for child requests and loop results.
interface mae_item_if;
  import mae_pkg::*;

  logic             valid;
  logic             ready;
  logic             first_child;
  logic             last_child;
  logic [IDX_W-1:0] loop_open;
  logic [IDX_W-1:0] loop_close;
  logic [IDX_W-1:0] child_open;
  logic [IDX_W-1:0] child_close;

  modport source (
    output valid, first_child, last_child, loop_open, loop_close, child_open, child_close,
    input  ready
  );
  modport sink (
    input  valid, first_child, last_child, loop_open, loop_close, child_open, child_close,
    output ready
  );
endinterface

interface mae_result_if;
  import mae_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [E_W-1:0] loop_energy;
  logic [TOT_W-1:0]      total_asymmetry;
  logic [BR_W-1:0]       branches_seen;
  logic [UP_W-1:0]       unpaired_seen;
  logic                  order_error;

  modport source (
    output valid, loop_energy, total_asymmetry, branches_seen, unpaired_seen, order_error,
    input  ready
  );
  modport sink (
    input  valid, loop_energy, total_asymmetry, branches_seen, unpaired_seen, order_error,
    output ready
  );
endinterface

// ===== rtl/core/mae_ctrl.sv =====
// Controller state machine: sequences gap accumulation, energy terms and the divider.
module mae_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_last,
  output logic                 item_ready,
  output logic                 result_valid,
  input  logic                 result_ready,
  input  mae_pkg::mae_status_t status,
  output mae_pkg::mae_cmd_t    cmd
);
  import mae_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIN_GAP,
    S_FIN_WRAP,
    S_MUL_CAP,
    S_MUL_BR,
    S_MUL_UP,
    S_MUL_ASYM,
    S_SCALE,
    S_DIV,
    S_SUM
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] div_cnt;
  logic             out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free   = !result_valid || result_ready;
  assign item_ready = (state == S_IDLE) && !rst;

  // State, divider count and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      div_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      // The flag drops when the result is taken, unless a new result is loaded now.
      if (result_valid && result_ready && (state != S_SUM)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid && item_last) begin
            state <= S_FIN_GAP;
          end
        end
        S_FIN_GAP:  state <= S_FIN_WRAP;
        S_FIN_WRAP: state <= S_MUL_CAP;
        S_MUL_CAP:  state <= S_MUL_BR;
        S_MUL_BR:   state <= S_MUL_UP;
        S_MUL_UP:   state <= S_MUL_ASYM;
        S_MUL_ASYM: state <= S_SCALE;
        S_SCALE: begin
          if (status.capped) begin
            state <= S_SUM;
          end else begin
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_SUM;
          end else begin
            div_cnt <= div_cnt + CNT_W'(1);
          end
        end
        S_SUM: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath commands decoded from the state.
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_CAP;
    unique case (state)
      S_IDLE:     cmd.take_item = item_valid;
      S_FIN_GAP:  cmd.fin_gap = 1'b1;
      S_FIN_WRAP: cmd.fin_wrap = 1'b1;
      S_MUL_CAP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CAP;
      end
      S_MUL_BR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BR;
        cmd.cmp_cap = 1'b1;
      end
      S_MUL_UP: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_UP;
        cmd.acc_init = 1'b1;
      end
      S_MUL_ASYM: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ASYM;
        cmd.acc_add = 1'b1;
      end
      S_SCALE:    cmd.scale = 1'b1;
      S_DIV:      cmd.div_step = 1'b1;
      S_SUM:      cmd.load_out = out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/mae_datapath.sv =====
// Datapath: gap accumulators, shared multiplier, restoring divider and result register.
module mae_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  mae_pkg::mae_cfg_t             cfg,
  input  mae_pkg::mae_cmd_t             cmd,
  output mae_pkg::mae_status_t          status,
  input  logic                          first_child,
  input  logic [mae_pkg::IDX_W-1:0]     loop_open,
  input  logic [mae_pkg::IDX_W-1:0]     loop_close,
  input  logic [mae_pkg::IDX_W-1:0]     child_open,
  input  logic [mae_pkg::IDX_W-1:0]     child_close,
  output logic signed [mae_pkg::E_W-1:0] loop_energy,
  output logic [mae_pkg::TOT_W-1:0]     total_asymmetry,
  output logic [mae_pkg::BR_W-1:0]      branches_seen,
  output logic [mae_pkg::UP_W-1:0]      unpaired_seen,
  output logic                          order_error
);
  import mae_pkg::*;

  localparam logic signed [ACC_E_W-1:0] E_HI =
    $signed({{(ACC_E_W - E_W + 1){1'b0}}, {(E_W - 1){1'b1}}});
  localparam logic signed [ACC_E_W-1:0] E_LO =
    $signed({{(ACC_E_W - E_W + 1){1'b1}}, {(E_W - 1){1'b0}}});

  // Loop state.
  logic [IDX_W-1:0]  first_gap;
  logic [IDX_W-1:0]  prev_gap;
  logic [IDX_W-1:0]  prev_child_close;
  logic [IDX_W-1:0]  loop_close_q;
  logic [ASYM_W-1:0] asym_acc;
  logic [BR_W-1:0]   branch_acc;
  logic [UP_W-1:0]   unpaired_acc;
  logic              error_seen;

  // Energy arithmetic registers.
  logic signed [PROD_W-1:0]  prod;
  logic                      capped;
  logic signed [ACC_E_W-1:0] acc_e;
  logic [REM_W-1:0]          rem;
  logic [Q_W-1:0]            quo;

  // Gap between two base indices, both exclusive; negative gaps count as zero.
  logic [IDX_W-1:0] gap_a;
  logic [IDX_W-1:0] gap_b;
  logic [IDX_W+1:0] gap_diff;
  logic             gap_neg;
  logic [IDX_W-1:0] gap_val;

  always_comb begin
    if (cmd.fin_gap) begin
      gap_a = prev_child_close;
      gap_b = loop_close_q;
    end else begin
      gap_a = first_child ? loop_open : prev_child_close;
      gap_b = child_open;
    end
    gap_diff = {2'b00, gap_b} - {2'b00, gap_a} - (IDX_W + 2)'(1);
    gap_neg  = gap_diff[IDX_W+1];
    gap_val  = gap_neg ? '0 : gap_diff[IDX_W-1:0];
  end

  // Saturating accumulation of a new gap and of the wrap back to the first gap.
  logic [IDX_W-1:0]  step_diff;
  logic [IDX_W-1:0]  wrap_diff;
  logic [ASYM_W:0]   asym_sum;
  logic [ASYM_W:0]   wrap_sum;
  logic [UP_W:0]     unp_sum;
  logic [ASYM_W-1:0] asym_take;
  logic [ASYM_W-1:0] asym_wrap;
  logic [UP_W-1:0]   unp_take;
  logic [BR_W-1:0]   branch_inc;

  always_comb begin
    step_diff  = (prev_gap > gap_val) ? prev_gap - gap_val : gap_val - prev_gap;
    wrap_diff  = (prev_gap > first_gap) ? prev_gap - first_gap : first_gap - prev_gap;
    asym_sum   = {1'b0, asym_acc} + (ASYM_W + 1)'(step_diff);
    wrap_sum   = {1'b0, asym_acc} + (ASYM_W + 1)'(wrap_diff);
    unp_sum    = {1'b0, unpaired_acc} + (UP_W + 1)'(gap_val);
    asym_take  = asym_sum[ASYM_W] ? '1 : asym_sum[ASYM_W-1:0];
    asym_wrap  = wrap_sum[ASYM_W] ? '1 : wrap_sum[ASYM_W-1:0];
    unp_take   = unp_sum[UP_W] ? '1 : unp_sum[UP_W-1:0];
    branch_inc = (&branch_acc) ? branch_acc : branch_acc + BR_W'(1);
  end

  // Loop state updates per child and for the closing gap.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_gap        <= '0;
      prev_gap         <= '0;
      prev_child_close <= '0;
      loop_close_q     <= '0;
      asym_acc         <= '0;
      branch_acc       <= '0;
      unpaired_acc     <= '0;
      error_seen       <= 1'b0;
    end else begin
      if (cmd.take_item) begin
        prev_child_close <= child_close;
        loop_close_q     <= loop_close;
        prev_gap         <= gap_val;
        if (first_child) begin
          error_seen   <= gap_neg;
          asym_acc     <= '0;
          first_gap    <= gap_val;
          unpaired_acc <= UP_W'(gap_val);
          branch_acc   <= BR_W'(BRANCH_BASE);
        end else begin
          error_seen   <= error_seen | gap_neg;
          asym_acc     <= asym_take;
          unpaired_acc <= unp_take;
          branch_acc   <= branch_inc;
        end
      end
      if (cmd.fin_gap) begin
        error_seen   <= error_seen | gap_neg;
        asym_acc     <= asym_take;
        unpaired_acc <= unp_take;
        prev_gap     <= gap_val;
      end
      if (cmd.fin_wrap) begin
        asym_acc <= asym_wrap;
      end
    end
  end

  // Coefficient magnitude; the sign is applied after rounding.
  logic signed [CMAG_W-1:0] coeff_ext;
  logic [CMAG_W-1:0]        c_mag;
  logic                     coeff_neg;

  assign coeff_neg = cfg.asym_coeff_q8[CFG_W-1];
  assign coeff_ext = {cfg.asym_coeff_q8[CFG_W-1], cfg.asym_coeff_q8};
  assign c_mag     = coeff_neg ? CMAG_W'(-coeff_ext) : CMAG_W'(coeff_ext);

  // Shared multiplier operand selection.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_CAP: begin
        mul_a = $signed(MUL_A_W'(cfg.max_avg_asym_q8));
        mul_b = $signed(MUL_B_W'(branch_acc));
      end
      MUL_BR: begin
        mul_a = $signed(MUL_A_W'(branch_acc));
        mul_b = MUL_B_W'($signed(cfg.branch_cost));
      end
      MUL_UP: begin
        mul_a = $signed(MUL_A_W'(unpaired_acc));
        mul_b = MUL_B_W'($signed(cfg.unpaired_cost));
      end
      MUL_ASYM: begin
        mul_a = capped ? $signed(MUL_A_W'(cfg.max_avg_asym_q8)) : $signed(MUL_A_W'(asym_acc));
        mul_b = $signed(MUL_B_W'(c_mag));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Scaling, rounding offsets and the divider step.
  logic                      strain_hit;
  logic [NUM_W-1:0]          num;
  logic [NUM_W-1:0]          round_sum;
  logic [NUM_W-1:0]          div_num;
  logic [REM_W:0]            div_trial;
  logic [REM_W:0]            div_sub;
  logic                      div_ge;
  logic signed [ACC_E_W-1:0] asym_val;
  logic signed [ACC_E_W-1:0] asym_term;
  logic signed [ACC_E_W-1:0] e_sum;
  logic [CMP_W-1:0]          avg_scaled;

  always_comb begin
    strain_hit = (branch_acc == BR_W'(STRAIN_BRANCHES)) &&
                 (unpaired_acc < UP_W'(STRAIN_UNPAIRED));
    avg_scaled = CMP_W'({asym_acc, {AVG_SHIFT{1'b0}}});
    num        = NUM_W'(prod[MAG_W-1:0]) * NUM_W'(ENERGY_SCALE);
    round_sum  = num + (NUM_W'(1) << (CAP_SHIFT - 1));
    div_num    = num + (NUM_W'(branch_acc) << HALF_SHIFT);
    div_trial  = {rem, quo[Q_W-1]};
    div_sub    = div_trial - (REM_W + 1)'(branch_acc);
    div_ge     = (div_trial >= (REM_W + 1)'(branch_acc));
    asym_val   = $signed(ACC_E_W'(quo));
    asym_term  = coeff_neg ? -asym_val : asym_val;
    e_sum      = acc_e + asym_term;
  end

  assign status.capped = capped;

  // Energy sequence registers and the result register.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= PROD_W'(mul_a * mul_b);
    end
    if (cmd.cmp_cap) begin
      capped <= (avg_scaled > prod[CMP_W-1:0]);
    end
    if (cmd.acc_init) begin
      acc_e <= ACC_E_W'($signed(cfg.init_cost)) + ACC_E_W'(prod) +
               (strain_hit ? ACC_E_W'($signed(cfg.strain_cost)) : '0);
    end
    if (cmd.acc_add) begin
      acc_e <= acc_e + ACC_E_W'(prod);
    end
    if (cmd.scale) begin
      if (capped) begin
        quo <= round_sum[CAP_SHIFT +: Q_W];
        rem <= '0;
      end else begin
        quo <= div_num[AVG_SHIFT +: Q_W];
        rem <= REM_W'(div_num[NUM_W-1:AVG_SHIFT+Q_W]);
      end
    end
    if (cmd.div_step) begin
      rem <= div_ge ? div_sub[REM_W-1:0] : div_trial[REM_W-1:0];
      quo <= {quo[Q_W-2:0], div_ge};
    end
    if (cmd.load_out) begin
      if (e_sum > E_HI) begin
        loop_energy <= E_HI[E_W-1:0];
      end else if (e_sum < E_LO) begin
        loop_energy <= E_LO[E_W-1:0];
      end else begin
        loop_energy <= e_sum[E_W-1:0];
      end
      total_asymmetry <= asym_acc[ASYM_W-1] ? '1 : asym_acc[TOT_W-1:0];
      branches_seen   <= branch_acc;
      unpaired_seen   <= unpaired_acc;
      order_error     <= error_seen;
    end
  end

endmodule

// ===== rtl/core/multiloop_asymmetry_energy.sv =====
// Top level: register file, controller and datapath of the multiloop energy block.
//
// Child pairs of one multiloop arrive in order on the item channel; each child that is
// not the last is taken and the next request may be taken in the following cycle. The last
// child starts the energy sequence: closing gap, wrap term, four passes through the one
// shared 19x18 multiplier, scaling and the final saturating sum. The divider is skipped
// when the average asymmetry exceeds the cap; otherwise the restoring divider produces
// the average one quotient bit per cycle. The result sits in an output register, so the
// next loop may start while it waits to be taken. The user writes registers over the APB
// at byte address 4*index only while the block is idle; the block does not enforce it.
module multiloop_asymmetry_energy (
  input  logic                             clk,
  input  logic                             rst,
  mae_item_if.sink                         item,
  mae_result_if.source                     result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mae_pkg::REG_ADDR_W-1:0]   paddr,
  input  logic [mae_pkg::APB_W-1:0]        pwdata,
  output logic [mae_pkg::APB_W-1:0]        prdata,
  output logic                             pready
);
  import mae_pkg::*;

  mae_cfg_t         cfg;
  mae_cmd_t         cmd;
  mae_status_t      status;
  logic [REG_IDX_W-1:0] reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[REG_ADDR_W-1:REG_ADDR_W-REG_IDX_W];
  assign wr_en   = psel && penable && pwrite;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_INIT:     cfg.init_cost       <= pwdata[CFG_W-1:0];
        REG_BRANCH:   cfg.branch_cost     <= pwdata[CFG_W-1:0];
        REG_UNPAIRED: cfg.unpaired_cost   <= pwdata[CFG_W-1:0];
        REG_STRAIN:   cfg.strain_cost     <= pwdata[CFG_W-1:0];
        REG_CAP:      cfg.max_avg_asym_q8 <= pwdata[CFG_W-1:0];
        REG_COEFF:    cfg.asym_coeff_q8   <= pwdata[CFG_W-1:0];
        default:      cfg <= cfg;
      endcase
    end
  end

  // Register read-back, signed fields sign-extended.
  always_comb begin
    unique case (reg_idx)
      REG_INIT:     prdata = APB_W'($signed(cfg.init_cost));
      REG_BRANCH:   prdata = APB_W'($signed(cfg.branch_cost));
      REG_UNPAIRED: prdata = APB_W'($signed(cfg.unpaired_cost));
      REG_STRAIN:   prdata = APB_W'($signed(cfg.strain_cost));
      REG_CAP:      prdata = APB_W'(cfg.max_avg_asym_q8);
      REG_COEFF:    prdata = APB_W'($signed(cfg.asym_coeff_q8));
      default:      prdata = '0;
    endcase
  end

  // Sequencing of each loop.
  mae_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_last    (item.last_child),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Accumulation and energy arithmetic.
  mae_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .status          (status),
    .first_child     (item.first_child),
    .loop_open       (item.loop_open),
    .loop_close      (item.loop_close),
    .child_open      (item.child_open),
    .child_close     (item.child_close),
    .loop_energy     (result.loop_energy),
    .total_asymmetry (result.total_asymmetry),
    .branches_seen   (result.branches_seen),
    .unpaired_seen   (result.unpaired_seen),
    .order_error     (result.order_error)
  );

endmodule
